// File: rtl/core/pgsc_pkg.sv
package pgsc_pkg;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_BIND   = 3'd2,
    KIND_RX     = 3'd3,
    KIND_TX     = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_ACKONLY   = 4'd1,
    ST_MALFORMED = 4'd2,
    ST_NOSESS    = 4'd3,
    ST_UNBOUND   = 4'd4,
    ST_STALE     = 4'd5,
    ST_DUP       = 4'd6,
    ST_FULL      = 4'd7,
    ST_INVALID   = 4'd8
  } status_e;

  localparam int unsigned BucketBits = 4;
  localparam logic [7:0]  GreKey     = 8'h20;
  localparam logic [7:0]  GreSeq     = 8'h10;
  localparam logic [7:0]  GreVer     = 8'h01;
  localparam logic [7:0]  GreAck     = 8'h80;
  localparam logic [7:0]  FlagMask   = 8'hEF;
  localparam logic [7:0]  VerMask    = 8'h7F;
  localparam logic [15:0] GreProto   = 16'h880B;
  localparam logic [15:0] PppAc      = 16'hFF03;
  localparam logic [15:0] HdrFull    = 16'd16;
  localparam logic [4:0]  HlenFull   = 5'd16;
  localparam logic [4:0]  HlenNoAck  = 5'd12;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] call;
    logic [15:0] peer_call;
    logic        bound;
    logic [31:0] rx_seq;
    logic [31:0] tx_seq;
    logic [31:0] ack_sent;
  } entry_t;

  function automatic logic [BucketBits-1:0] bucket_of(input logic [31:0] addr,
                                                      input logic [15:0] cid);
    bucket_of = addr[3:0] ^ addr[7:4] ^ cid[3:0] ^ cid[7:4];
  endfunction

endpackage

// File: rtl/core/pptp_gre_session_classifier.sv
// channel | direction | signals
// command | in        | start_i, busy_o, kind_i .. next_word_i
// result  | out       | done_o, status_o .. payload_length_o
// busy_o is high from the accepting edge until the transaction is through: one entry memory
// read per way, a compare of the last read data, then a state to decide and write
// back. The result appears on the ports with done_o, which is high for one cycle, when
// busy_o is already low; a new transaction is accepted only while busy_o is low.
// Reset clears the control state and all entry valid bits at once.
// The receiver cannot stall; no result is held.
module pptp_gre_session_classifier #(
  parameter int unsigned WAYS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  kind_i,
  input  logic [31:0] peer_addr_i,
  input  logic [15:0] call_id_i,
  input  logic [15:0] peer_call_id_i,
  input  logic [15:0] packet_length_i,
  input  logic [7:0]  gre_flags_i,
  input  logic [7:0]  gre_version_i,
  input  logic [15:0] gre_protocol_i,
  input  logic [31:0] gre_seq_i,
  input  logic [15:0] next_word_i,
  output logic        done_o,
  output logic [3:0]  status_o,
  output logic [5:0]  slot_o,
  output logic [4:0]  header_length_o,
  output logic [31:0] send_seq_o,
  output logic        ack_present_o,
  output logic [31:0] ack_value_o,
  output logic [15:0] out_call_id_o,
  output logic [15:0] payload_length_o
);
  localparam int unsigned WayW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned Entries = 16 * WAYS;
  localparam int unsigned IdxW    = pgsc_pkg::BucketBits + WayW;
  localparam int unsigned CntW    = $clog2(WAYS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   rd_cnt_q;
  logic [CntW-1:0]   cmp_cnt_q;
  logic              cmp_v_q;
  logic [Entries-1:0] valid_q;
  logic [2:0]  kind_q;
  logic [31:0] addr_q, seq_q;
  logic [15:0] cid_q, pcid_q, plen_q, proto_q, nword_q;
  logic [7:0]  flags_q, ver_q;
  logic        hit_q, free_q;
  logic [WayW-1:0] hit_way_q, free_way_q;
  pgsc_pkg::entry_t hit_ent_q;
  logic [pgsc_pkg::BucketBits-1:0] bkt;
  logic [IdxW-1:0] raddr, cmp_idx, hit_idx, free_idx, waddr;
  pgsc_pkg::entry_t rdata, wdata;
  logic        we;
  logic        cmp_match;

  assign bkt     = pgsc_pkg::bucket_of(addr_q, cid_q);
  assign raddr   = IdxW'(bkt) * IdxW'(WAYS) + IdxW'(rd_cnt_q[WayW-1:0]);
  assign cmp_idx = IdxW'(bkt) * IdxW'(WAYS) + IdxW'(cmp_cnt_q[WayW-1:0]);
  assign hit_idx = IdxW'(bkt) * IdxW'(WAYS) + IdxW'(hit_way_q);
  assign free_idx = IdxW'(bkt) * IdxW'(WAYS) + IdxW'(free_way_q);
  assign cmp_match = valid_q[cmp_idx] && rdata.addr == addr_q && rdata.call == cid_q;

  pgsc_table #(.Depth(Entries), .AddrW(IdxW)) u_table (
    .clk_i   (clk_i),
    .raddr_i (raddr),
    .rdata_o (rdata),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata)
  );

  assign busy_o = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start_i) state_d = S_SCAN;
      S_SCAN:  if (cmp_v_q && cmp_cnt_q == CntW'(WAYS - 1)) state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_cnt_q  <= '0;
      cmp_cnt_q <= '0;
      cmp_v_q   <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      done_o    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= state_q == S_DONE;
      case (state_q)
        S_IDLE: begin
          rd_cnt_q <= '0;
          cmp_v_q  <= 1'b0;
          hit_q    <= 1'b0;
          free_q   <= 1'b0;
        end
        S_SCAN: begin
          if (rd_cnt_q != CntW'(WAYS)) begin
            rd_cnt_q <= rd_cnt_q + 1'b1;
          end
          cmp_v_q   <= rd_cnt_q != CntW'(WAYS);
          cmp_cnt_q <= rd_cnt_q;
          if (cmp_v_q) begin
            if (cmp_match && !hit_q) begin
              hit_q <= 1'b1;
            end
            if (!valid_q[cmp_idx] && !free_q) begin
              free_q <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      kind_q  <= kind_i;
      addr_q  <= peer_addr_i;
      cid_q   <= call_id_i;
      pcid_q  <= peer_call_id_i;
      plen_q  <= packet_length_i;
      flags_q <= gre_flags_i;
      ver_q   <= gre_version_i;
      proto_q <= gre_protocol_i;
      seq_q   <= gre_seq_i;
      nword_q <= next_word_i;
    end
    if (state_q == S_SCAN && cmp_v_q) begin
      if (cmp_match && !hit_q) begin
        hit_way_q <= cmp_cnt_q[WayW-1:0];
        hit_ent_q <= rdata;
      end
      if (!valid_q[cmp_idx] && !free_q) begin
        free_way_q <= cmp_cnt_q[WayW-1:0];
      end
    end
  end

  function automatic logic av_diff_neg(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    av_diff_neg = d[31];
  endfunction

  logic [3:0]  st;
  logic [IdxW-1:0] sl;
  logic [4:0]  hl;
  logic [31:0] ss, av;
  logic        ap;
  logic [15:0] oc, ol;
  logic        set_v, clr_v;

  always_comb begin
    st = pgsc_pkg::ST_MALFORMED;
    sl = '0; hl = '0; ss = '0; ap = 1'b0; av = '0; oc = '0; ol = '0;
    we = 1'b0; waddr = hit_idx; wdata = hit_ent_q;
    set_v = 1'b0; clr_v = 1'b0;
    case (kind_q)
      pgsc_pkg::KIND_INSERT: begin
        if (cid_q == '0) st = pgsc_pkg::ST_INVALID;
        else if (hit_q) begin
          st = pgsc_pkg::ST_DUP; sl = hit_idx;
        end else if (free_q) begin
          st = pgsc_pkg::ST_OK; sl = free_idx;
          we = 1'b1; waddr = free_idx; set_v = 1'b1;
          wdata.addr = addr_q; wdata.call = cid_q; wdata.peer_call = pcid_q;
          wdata.bound = 1'b0; wdata.rx_seq = '0; wdata.tx_seq = '0;
          wdata.ack_sent = '0;
        end else st = pgsc_pkg::ST_FULL;
      end
      pgsc_pkg::KIND_DELETE: begin
        if (cid_q == '0) st = pgsc_pkg::ST_INVALID;
        else if (!hit_q) st = pgsc_pkg::ST_NOSESS;
        else begin
          st = pgsc_pkg::ST_OK; sl = hit_idx; clr_v = 1'b1;
        end
      end
      pgsc_pkg::KIND_BIND: begin
        if (!hit_q) st = pgsc_pkg::ST_NOSESS;
        else begin
          st = pgsc_pkg::ST_OK; sl = hit_idx; we = 1'b1; wdata.bound = 1'b1;
        end
      end
      pgsc_pkg::KIND_RX: begin
        if (plen_q < pgsc_pkg::HdrFull) st = pgsc_pkg::ST_MALFORMED;
        else if (!hit_q) st = pgsc_pkg::ST_NOSESS;
        else begin
          sl = hit_idx;
          if (!hit_ent_q.bound) st = pgsc_pkg::ST_UNBOUND;
          else if (plen_q < pgsc_pkg::HdrFull + 16'd2 ||
                   (flags_q & pgsc_pkg::FlagMask) != pgsc_pkg::GreKey ||
                   (ver_q & pgsc_pkg::VerMask) != pgsc_pkg::GreVer ||
                   proto_q != pgsc_pkg::GreProto) st = pgsc_pkg::ST_MALFORMED;
          else if ((flags_q & pgsc_pkg::GreSeq) == '0) st = pgsc_pkg::ST_ACKONLY;
          else if (hit_ent_q.rx_seq != '0 && av_diff_neg(seq_q, hit_ent_q.rx_seq))
            st = pgsc_pkg::ST_STALE;
          else begin
            st = pgsc_pkg::ST_OK;
            hl = ((ver_q & pgsc_pkg::GreAck) != '0) ? pgsc_pkg::HlenFull
                                                     : pgsc_pkg::HlenNoAck;
            if (nword_q == pgsc_pkg::PppAc) hl = hl + 5'd2;
            we = 1'b1; wdata.rx_seq = seq_q;
          end
        end
      end
      pgsc_pkg::KIND_TX: begin
        if (!hit_q) st = pgsc_pkg::ST_NOSESS;
        else begin
          st = pgsc_pkg::ST_OK; sl = hit_idx; we = 1'b1;
          ol = plen_q + 16'd2;
          if (hit_ent_q.ack_sent != hit_ent_q.rx_seq) begin
            ap = 1'b1; av = hit_ent_q.rx_seq; wdata.ack_sent = hit_ent_q.rx_seq;
            hl = pgsc_pkg::HlenFull;
          end else hl = pgsc_pkg::HlenNoAck;
          ss = hit_ent_q.tx_seq; wdata.tx_seq = hit_ent_q.tx_seq + 32'd1;
          oc = hit_ent_q.peer_call;
        end
      end
      default: ;
    endcase
    if (state_q != S_DONE) begin
      we = 1'b0; set_v = 1'b0; clr_v = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (set_v) begin
      valid_q[waddr] <= 1'b1;
    end else if (clr_v) begin
      valid_q[hit_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE) begin
      status_o         <= st;
      slot_o           <= 6'(sl);
      header_length_o  <= hl;
      send_seq_o       <= ss;
      ack_present_o    <= ap;
      ack_value_o      <= av;
      out_call_id_o    <= oc;
      payload_length_o <= ol;
    end
  end
endmodule

// File: rtl/core/pgsc_table.sv
module pgsc_table #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic                 clk_i,
  input  logic [AddrW-1:0]     raddr_i,
  output pgsc_pkg::entry_t     rdata_o,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  pgsc_pkg::entry_t     wdata_i
);
  pgsc_pkg::entry_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: dv/tb_pptp_gre_session_classifier.sv
module tb_pptp_gre_session_classifier;
  import pgsc_pkg::*;

  localparam int unsigned WAYS    = 4;
  localparam int unsigned ENTRIES = 16 * WAYS;
  localparam int unsigned NKEYS   = 28;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] addr;
    logic [15:0] cid;
    logic [15:0] pcid;
    logic [15:0] plen;
    logic [7:0]  flags;
    logic [7:0]  ver;
    logic [15:0] proto;
    logic [31:0] seq;
    logic [15:0] nword;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [5:0]  slot;
    logic [4:0]  hlen;
    logic [31:0] sseq;
    logic        ackp;
    logic [31:0] ackv;
    logic [15:0] ocid;
    logic [15:0] olen;
  } verdict_t;

  class session_board;
    bit          valid[ENTRIES];
    bit          bound[ENTRIES];
    logic [31:0] addr[ENTRIES];
    logic [15:0] call[ENTRIES];
    logic [15:0] peer_call[ENTRIES];
    logic [31:0] rx_seq[ENTRIES];
    logic [31:0] tx_seq[ENTRIES];
    logic [31:0] ack_sent[ENTRIES];
    verdict_t    verdict_q[$];
    int          failures;

    function new();
      foreach (valid[i]) begin
        valid[i] = 0;
        bound[i] = 0;
      end
      failures = 0;
    endfunction

    function int bucket_base(logic [31:0] a, logic [15:0] c);
      logic [3:0] b;
      b = a[3:0] ^ a[7:4] ^ c[3:0] ^ c[7:4];
      return b * WAYS;
    endfunction

    function int lookup(logic [31:0] a, logic [15:0] c);
      int base;
      base = bucket_base(a, c);
      for (int w = 0; w < WAYS; w++)
        if (valid[base+w] && addr[base+w] == a && call[base+w] == c) return base + w;
      return -1;
    endfunction

    function void note_command(cmd_t c);
      verdict_t   r;
      int         e;
      int         base;
      logic [31:0] diff;
      r = '0;
      r.status = ST_MALFORMED;
      case (c.kind)
        KIND_INSERT: begin
          if (c.cid == 0) r.status = ST_INVALID;
          else begin
            e = lookup(c.addr, c.cid);
            if (e >= 0) begin
              r.status = ST_DUP;
              r.slot = 6'(e);
            end else begin
              base = bucket_base(c.addr, c.cid);
              r.status = ST_FULL;
              for (int w = 0; w < WAYS; w++) begin
                if (!valid[base+w]) begin
                  valid[base+w] = 1;
                  addr[base+w] = c.addr;
                  call[base+w] = c.cid;
                  peer_call[base+w] = c.pcid;
                  bound[base+w] = 0;
                  rx_seq[base+w] = 0;
                  tx_seq[base+w] = 0;
                  ack_sent[base+w] = 0;
                  r.status = ST_OK;
                  r.slot = 6'(base + w);
                  break;
                end
              end
            end
          end
        end
        KIND_DELETE: begin
          if (c.cid == 0) r.status = ST_INVALID;
          else begin
            e = lookup(c.addr, c.cid);
            if (e < 0) r.status = ST_NOSESS;
            else begin
              valid[e] = 0;
              bound[e] = 0;
              r.status = ST_OK;
              r.slot = 6'(e);
            end
          end
        end
        KIND_BIND: begin
          e = lookup(c.addr, c.cid);
          if (e < 0) r.status = ST_NOSESS;
          else begin
            bound[e] = 1;
            r.status = ST_OK;
            r.slot = 6'(e);
          end
        end
        KIND_RX: begin
          if (c.plen < HdrFull) r.status = ST_MALFORMED;
          else begin
            e = lookup(c.addr, c.cid);
            if (e < 0) r.status = ST_NOSESS;
            else begin
              r.slot = 6'(e);
              diff = c.seq - rx_seq[e];
              if (!bound[e]) r.status = ST_UNBOUND;
              else if (c.plen < HdrFull + 2 || (c.flags & FlagMask) != GreKey ||
                       (c.ver & VerMask) != GreVer || c.proto != GreProto)
                r.status = ST_MALFORMED;
              else if ((c.flags & GreSeq) == 0) r.status = ST_ACKONLY;
              else if (rx_seq[e] != 0 && diff[31]) r.status = ST_STALE;
              else begin
                r.hlen = (c.ver & GreAck) ? HlenFull : HlenNoAck;
                if (c.nword == PppAc) r.hlen = r.hlen + 5'd2;
                rx_seq[e] = c.seq;
                r.status = ST_OK;
              end
            end
          end
        end
        KIND_TX: begin
          e = lookup(c.addr, c.cid);
          if (e < 0) r.status = ST_NOSESS;
          else begin
            r.slot = 6'(e);
            r.olen = c.plen + 16'd2;
            if (ack_sent[e] != rx_seq[e]) begin
              r.ackp = 1;
              r.ackv = rx_seq[e];
              ack_sent[e] = rx_seq[e];
              r.hlen = HlenFull;
            end else begin
              r.hlen = HlenNoAck;
            end
            r.sseq = tx_seq[e];
            tx_seq[e] = tx_seq[e] + 1;
            r.ocid = peer_call[e];
            r.status = ST_OK;
          end
        end
        default: r.status = ST_MALFORMED;
      endcase
      verdict_q.push_back(r);
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result %h", got);
        return;
      end
      want = verdict_q.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10)
          $display({"mismatch: expected st=%0d slot=%0d hl=%0d sq=%h ak=%b/%h cid=%h len=%h,",
                    " got st=%0d slot=%0d hl=%0d sq=%h ak=%b/%h cid=%h len=%h"},
                   want.status, want.slot, want.hlen, want.sseq, want.ackp, want.ackv,
                   want.ocid, want.olen, got.status, got.slot, got.hlen, got.sseq,
                   got.ackp, got.ackv, got.ocid, got.olen);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  logic        busy_o;
  logic [2:0]  kind_i = '0;
  logic [31:0] peer_addr_i = '0;
  logic [15:0] call_id_i = '0;
  logic [15:0] peer_call_id_i = '0;
  logic [15:0] packet_length_i = '0;
  logic [7:0]  gre_flags_i = '0;
  logic [7:0]  gre_version_i = '0;
  logic [15:0] gre_protocol_i = '0;
  logic [31:0] gre_seq_i = '0;
  logic [15:0] next_word_i = '0;
  logic        done_o;
  logic [3:0]  status_o;
  logic [5:0]  slot_o;
  logic [4:0]  header_length_o;
  logic [31:0] send_seq_o;
  logic        ack_present_o;
  logic [31:0] ack_value_o;
  logic [15:0] out_call_id_o;
  logic [15:0] payload_length_o;

  pptp_gre_session_classifier #(.WAYS(WAYS)) dut (.*);

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  session_board sb = new();

  logic [31:0] key_addr[NKEYS];
  logic [15:0] key_cid[NKEYS];
  logic [31:0] key_seq[NKEYS];

  always @(posedge clk_i) begin
    if (done_o)
      sb.check_result({status_o, slot_o, header_length_o, send_seq_o, ack_present_o,
                       ack_value_o, out_call_id_o, payload_length_o});
  end

  function automatic cmd_t mk(logic [2:0] kind, logic [31:0] a, logic [15:0] c,
                              logic [15:0] plen = 16'd18, logic [7:0] flags = 8'h30,
                              logic [7:0] ver = 8'h81, logic [15:0] proto = GreProto,
                              logic [31:0] seq = 0, logic [15:0] nword = PppAc);
    cmd_t m;
    m.kind = kind;
    m.addr = a;
    m.cid = c;
    m.pcid = c ^ 16'h5A5A;
    m.plen = plen;
    m.flags = flags;
    m.ver = ver;
    m.proto = proto;
    m.seq = seq;
    m.nword = nword;
    return m;
  endfunction

  function automatic void make_key(input logic [3:0] b, output logic [31:0] a,
                                   output logic [15:0] c);
    a = $urandom;
    c = 16'($urandom_range(1, 65535));
    c[3:0] = b ^ a[3:0] ^ a[7:4] ^ c[7:4];
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t m;
    int   k;
    int   roll;
    k = $urandom_range(0, NKEYS - 1);
    m = mk(KIND_RX, key_addr[k], key_cid[k], 16'($urandom_range(18, 65533)));
    m.pcid = 16'($urandom);
    if ($urandom_range(0, 99) < 15) begin
      m = {$urandom, $urandom, $urandom, $urandom, $urandom, 3'($urandom)};
      return m;
    end
    roll = $urandom_range(0, 99);
    if (roll < 20) m.kind = KIND_INSERT;
    else if (roll < 28) m.kind = KIND_DELETE;
    else if (roll < 40) m.kind = KIND_BIND;
    else if (roll < 80) m.kind = KIND_RX;
    else m.kind = KIND_TX;
    if (m.kind == KIND_TX && $urandom_range(0, 9) == 0)
      m.plen = 16'($urandom_range(65530, 65535));
    if (m.kind == KIND_RX) begin
      m.ver = {1'($urandom), 7'h01};
      m.nword = $urandom_range(0, 1) ? PppAc : 16'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 10) m.seq = key_seq[k] - $urandom_range(1, 1000);
      else if (roll < 13) m.seq = key_seq[k] + 32'h8000_0000;
      else begin
        key_seq[k] = key_seq[k] + $urandom_range(0, 1000);
        m.seq = key_seq[k];
      end
      roll = $urandom_range(0, 99);
      if (roll < 8) m.flags = 8'h20;
      else if (roll < 11) m.flags = m.flags ^ (8'h1 << $urandom_range(0, 7));
      else if (roll < 14) m.ver = m.ver ^ (8'h1 << $urandom_range(0, 6));
      else if (roll < 17) m.proto = m.proto ^ (16'h1 << $urandom_range(0, 15));
      else if (roll < 20) m.plen = 16'($urandom_range(0, 17));
    end
    return m;
  endfunction

  task automatic send(input cmd_t c);
    start_i <= 1;
    kind_i <= c.kind;
    peer_addr_i <= c.addr;
    call_id_i <= c.cid;
    peer_call_id_i <= c.pcid;
    packet_length_i <= c.plen;
    gre_flags_i <= c.flags;
    gre_version_i <= c.ver;
    gre_protocol_i <= c.proto;
    gre_seq_i <= c.seq;
    next_word_i <= c.nword;
    do @(posedge clk_i); while (!(start_i && !busy_o));
    sb.note_command(c);
  endtask

  initial begin
    #(12 * 2000000);
    $display("tb_pptp_gre_session_classifier NOT OK");
    $finish;
  end

  initial begin
    cmd_t        dir_q[$];
    logic [31:0] a;
    logic [15:0] c;
    logic [31:0] ka;
    logic [15:0] kc;
    int          burst;
    int          gap;
    for (int i = 0; i < NKEYS; i++) begin
      make_key(4'(i % 6), key_addr[i], key_cid[i]);
      key_seq[i] = $urandom;
    end
    a = 32'hC0A8_0001;
    c = 16'h1234;
    dir_q.push_back(mk(KIND_INSERT, a, c));
    dir_q.push_back(mk(KIND_INSERT, a, c));
    dir_q.push_back(mk(KIND_INSERT, a, 16'h0000));
    dir_q.push_back(mk(KIND_DELETE, a, 16'h0000));
    dir_q.push_back(mk(KIND_RX, 32'hFFFF_FFFF, 16'hFFFF));
    dir_q.push_back(mk(KIND_RX, a, c, 16'd15));
    dir_q.push_back(mk(KIND_RX, a, c));
    dir_q.push_back(mk(KIND_BIND, 32'h0, 16'h1));
    dir_q.push_back(mk(KIND_BIND, a, c));
    dir_q.push_back(mk(KIND_RX, a, c, 16'd17));
    dir_q.push_back(mk(KIND_RX, a, c, 16'd18, 8'h31));
    dir_q.push_back(mk(KIND_RX, a, c, 16'd18, 8'h30, 8'h82));
    dir_q.push_back(mk(KIND_RX, a, c, 16'd18, 8'h30, 8'h81, 16'h880A));
    dir_q.push_back(mk(KIND_RX, a, c, 16'd65533, 8'h20));
    dir_q.push_back(mk(KIND_RX, a, c, 16'd18, 8'h30, 8'h81, GreProto, 32'd100));
    dir_q.push_back(mk(KIND_RX, a, c, 16'd18, 8'h30, 8'h01, GreProto, 32'd50, 16'h0));
    dir_q.push_back(mk(KIND_RX, a, c, 16'd18, 8'h30, 8'h01, GreProto, 32'd100, 16'h0));
    dir_q.push_back(mk(KIND_TX, a, c, 16'd0));
    dir_q.push_back(mk(KIND_TX, a, c, 16'hFFFF));
    for (int i = 0; i < 4; i++) begin
      make_key(4'd6, ka, kc);
      dir_q.push_back(mk(KIND_INSERT, ka, kc));
    end
    dir_q.push_back(mk(KIND_DELETE, a, c));
    dir_q.push_back(mk(KIND_DELETE, a, c));
    dir_q.push_back(mk(3'd7, a, c));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    foreach (dir_q[i]) send(dir_q[i]);
    for (int n = 0; n < 1350; n += burst) begin
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst; j++) send(random_cmd());
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        start_i <= 0;
        repeat (gap) @(posedge clk_i);
      end
    end
    start_i <= 0;
    while (sb.verdict_q.size() > 0) @(posedge clk_i);
    repeat (WAYS + 8) @(posedge clk_i);
    if (sb.failures == 0 && sb.verdict_q.size() == 0) begin
      $display("tb_pptp_gre_session_classifier OK");
    end else begin
      $display("tb_pptp_gre_session_classifier NOT OK");
    end
    $finish;
  end
endmodule
